// ===== rtl/core/tpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_pkg: shared definitions for the three-class priority queue
// Types, class codes, operation codes and the command and status groups that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int CapacityDefault = 16;

  localparam int TagW   = 32;
  localparam int AgeW   = 8;
  localparam int CountW = 5;

  localparam logic [AgeW-1:0] SeniorAgeReset = 8'd65;

  // Operation codes of an input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Priority classes; a lower code is served first.
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_PREGNANT = 2'd0;
  localparam cls_t CLS_SENIOR   = 2'd1;
  localparam cls_t CLS_OTHER    = 2'd2;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [AgeW-1:0] age;
    logic            preg;
    cls_t            cls;
  } entry_t;

  typedef struct packed {
    logic load;        // capture the input item
    logic push;        // insert the captured record
    logic pop;         // remove the head record
    logic fail_full;   // push refused, queue full
    logic fail_empty;  // pop refused, queue empty
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/three_class_priority_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_priority_fifo: bounded queue with three strict priority classes
//
// Channel   Direction  Handshake                 Payload
// input     in         start & !busy             op, record_tag, age, pregnant
// result    out        done (one-cycle strobe)   accepted, empty_error,
//                                                full_error, front_tag,
//                                                front_age, front_pregnant,
//                                                entry_count
// config    in         cfg_wr_en                 cfg_wr_data (senior age)
//
// Each item passes the execute state, in which the cell chain inserts or
// shifts out a record and the result registers are loaded, and then the
// result state, in which the result is presented with done high. A new
// item may be started in that result state, so the block takes a new item
// while the last result is shown. Reset (rst, synchronous)
// empties the queue and sets the senior age threshold to 65; the contents of
// the cells are left as they are. The receiver cannot stall: every result is
// shown for exactly one cycle.
// ----------------------------------------------------------------------------
module three_class_priority_fifo #(
  parameter int CAPACITY = tpf_pkg::CapacityDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input items.
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic [tpf_pkg::TagW-1:0]   record_tag,
  input  wire logic [tpf_pkg::AgeW-1:0]   age,
  input  wire logic                       pregnant,
  // Configuration.
  input  wire logic                       cfg_wr_en,
  input  wire logic [tpf_pkg::AgeW-1:0]   cfg_wr_data,
  // Results.
  output logic                            done,
  output logic                            accepted,
  output logic                            empty_error,
  output logic                            full_error,
  output logic [tpf_pkg::TagW-1:0]        front_tag,
  output logic [tpf_pkg::AgeW-1:0]        front_age,
  output logic                            front_pregnant,
  output logic [tpf_pkg::CountW-1:0]      entry_count
);

  tpf_pkg::ctrl_cmd_t  cmd;
  tpf_pkg::dp_status_t status;

  // The controller steps each item from capture through execution to the
  // result cycle and decides from the queue status whether it succeeds.
  tpf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the records in a chain of cells kept in priority
  // order. A push finds its slot in parallel: every cell compares its class
  // with the new one, the first cell of a lower class takes the new record
  // and the cells behind it move one place along. A pop moves every cell one
  // place towards the head.
  tpf_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .op             (op),
    .record_tag     (record_tag),
    .age            (age),
    .pregnant       (pregnant),
    .accepted       (accepted),
    .empty_error    (empty_error),
    .full_error     (full_error),
    .front_tag      (front_tag),
    .front_age      (front_age),
    .front_pregnant (front_pregnant),
    .entry_count    (entry_count)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_ctrl: queue controller
// Sequences capture, execution and result of each item.
// ----------------------------------------------------------------------------
module tpf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire tpf_pkg::dp_status_t status,
  output tpf_pkg::ctrl_cmd_t      cmd,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state == ST_EXEC);
  assign done = (state == ST_RESP);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE, ST_RESP: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (status.is_pop) begin
          cmd.pop        = !status.empty;
          cmd.fail_empty = status.empty;
        end else begin
          cmd.push      = !status.full;
          cmd.fail_full = status.full;
        end
        state_next = ST_RESP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpf_datapath: queue datapath
// Threshold register, input capture, the ordered cell chain and result
// registers.
// ----------------------------------------------------------------------------
module tpf_datapath #(
  parameter int CAPACITY = tpf_pkg::CapacityDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tpf_pkg::ctrl_cmd_t         cmd,
  output tpf_pkg::dp_status_t             status,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tpf_pkg::AgeW-1:0]   cfg_wr_data,
  input  wire logic                       op,
  input  wire logic [tpf_pkg::TagW-1:0]   record_tag,
  input  wire logic [tpf_pkg::AgeW-1:0]   age,
  input  wire logic                       pregnant,
  output logic                            accepted,
  output logic                            empty_error,
  output logic                            full_error,
  output logic [tpf_pkg::TagW-1:0]        front_tag,
  output logic [tpf_pkg::AgeW-1:0]        front_age,
  output logic                            front_pregnant,
  output logic [tpf_pkg::CountW-1:0]      entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [tpf_pkg::AgeW-1:0] senior_age;
  logic                     op_q;
  tpf_pkg::entry_t          new_entry;
  tpf_pkg::cls_t            new_cls;
  tpf_pkg::entry_t          cells [CAPACITY];
  logic [CW-1:0]            held_count;
  logic [CAPACITY-1:0]      after;

  always_ff @(posedge clk) begin
    if (rst) begin
      senior_age <= tpf_pkg::SeniorAgeReset;
    end else if (cfg_wr_en) begin
      senior_age <= cfg_wr_data;
    end
  end

  always_comb begin
    if (pregnant) begin
      new_cls = tpf_pkg::CLS_PREGNANT;
    end else if (age >= senior_age) begin
      new_cls = tpf_pkg::CLS_SENIOR;
    end else begin
      new_cls = tpf_pkg::CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q           <= op;
      new_entry.tag  <= record_tag;
      new_entry.age  <= age;
      new_entry.preg <= pregnant;
      new_entry.cls  <= new_cls;
    end
  end

  assign status.is_pop = (op_q == tpf_pkg::OP_POP);
  assign status.full   = (held_count == CW'(CAPACITY));
  assign status.empty  = (held_count == '0);

  // A cell lies after the insert point when it is unused or holds a lower
  // class; held cells stay sorted, so this mark is monotone along the chain.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      after[i] = (CW'(i) >= held_count) || (cells[i].cls > new_entry.cls);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.push) begin
        if (i == 0) begin
          if (after[i]) begin
            cells[i] <= new_entry;
          end
        end else if (after[i-1]) begin
          cells[i] <= cells[i-1];
        end else if (after[i]) begin
          cells[i] <= new_entry;
        end
      end else if (cmd.pop) begin
        if (i < CAPACITY - 1) begin
          cells[i] <= cells[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.push) begin
      held_count <= held_count + CW'(1);
    end else if (cmd.pop) begin
      held_count <= held_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.pop || cmd.fail_full || cmd.fail_empty) begin
      accepted       <= cmd.push || cmd.pop;
      empty_error    <= cmd.fail_empty;
      full_error     <= cmd.fail_full;
      front_tag      <= cmd.pop ? cells[0].tag : '0;
      front_age      <= cmd.pop ? cells[0].age : '0;
      front_pregnant <= cmd.pop ? cells[0].preg : 1'b0;
    end
  end

  // The count register already holds the value after the operation.
  always_comb begin
    entry_count = tpf_pkg::CountW'(held_count);
  end

endmodule
`default_nettype wire
